// ===== design/lhr_pkg.sv =====
// shared types and constants for the largest histogram rectangle unit
// no dependencies; used by the channel interfaces and the top level
package lhr_pkg;

    localparam int BarHeightW = 32;
    localparam int MaxAreaW   = 42;

    typedef struct packed {
        logic [BarHeightW-1:0] bar_height;
        logic                  last;
    } bar_beat_t;

    typedef struct packed {
        logic [MaxAreaW-1:0] max_area;
        logic                overflow;
    } result_beat_t;

endpackage

// ===== design/lhr_bar_if.sv =====
// valid/ready channel carrying one histogram bar per beat
// depends on lhr_pkg
interface lhr_bar_if;
    import lhr_pkg::*;

    logic      valid;
    logic      ready;
    bar_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/lhr_result_if.sv =====
// valid/ready channel carrying one area result per beat
// depends on lhr_pkg
interface lhr_result_if;
    import lhr_pkg::*;

    logic         valid;
    logic         ready;
    result_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/lhr_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module lhr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== design/largest_histogram_rectangle_unit.sv =====
// Largest rectangle in a histogram. Bars arrive one per beat and are written
// to a height ram; the beat with last set closes the histogram. Bars beyond
// MAX_BARS are dropped and the result reports overflow. On close the block
// scans the stored bars with a monotonic stack held in a second ram (each
// entry keeps its height and left bound); the area of a popped bar is its
// height times its span. Loading accepts one bar per cycle. For each stored
// bar the scan reads its height (S_HRD, S_HCAP), then compares it with the
// stack top (S_CMP); each pop, one per bar, registers the area product and
// reads the new top from the stack ram (S_POPW). No bar is taken during the
// scan. The result sits in an output register, so the next histogram can
// load while it waits. Depends on lhr_pkg, lhr_bar_if, lhr_result_if, lhr_ram.
module largest_histogram_rectangle_unit #(
    parameter int MAX_BARS    = 1024,
    parameter int HEIGHT_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    lhr_bar_if.sink      bars,
    lhr_result_if.source result
);
    import lhr_pkg::*;

    localparam int IW     = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
    localparam int CW     = $clog2(MAX_BARS + 1);
    localparam int HB     = HEIGHT_BITS;
    localparam int AREA_W = HB + CW;
    localparam int EXT_W  = (AREA_W > MaxAreaW) ? AREA_W : MaxAreaW;
    localparam int SW     = IW + HB;

    typedef enum logic [5:0] {
        S_LOAD = 6'b000001,
        S_HRD  = 6'b000010,
        S_HCAP = 6'b000100,
        S_CMP  = 6'b001000,
        S_POPW = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                dropped_reg, dropped_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       sp_reg, sp_next;
    logic [HB-1:0]       cur_h_reg, cur_h_next;
    logic [HB-1:0]       top_h_reg, top_h_next;
    logic [IW-1:0]       top_left_reg, top_left_next;
    logic [CW-1:0]       push_left_reg, push_left_next;
    logic [AREA_W-1:0]   prod_reg, prod_next;
    logic [AREA_W-1:0]   best_reg, best_next;
    logic                out_valid_reg, out_valid_next;
    logic [MaxAreaW-1:0] out_area_reg, out_area_next;
    logic                out_ovf_reg, out_ovf_next;

    // height ram ports
    logic          h_we, h_re;
    logic [IW-1:0] h_waddr, h_raddr;
    logic [HB-1:0] h_wdata, h_rdata;

    // stack ram ports
    logic          s_we, s_re;
    logic [IW-1:0] s_waddr, s_raddr;
    logic [SW-1:0] s_wdata, s_rdata;

    logic              bar_accept;
    logic [CW-1:0]     span;
    logic [AREA_W-1:0] area;
    logic [EXT_W-1:0]  best_ext;

    lhr_ram #(.WIDTH(HB), .DEPTH(MAX_BARS)) u_height_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .re    (h_re),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    lhr_ram #(.WIDTH(SW), .DEPTH(MAX_BARS)) u_stack_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign bars.ready  = (state_reg == S_LOAD);
    assign bar_accept  = bars.valid && bars.ready;

    assign result.valid         = out_valid_reg;
    assign result.data.max_area = out_area_reg;
    assign result.data.overflow = out_ovf_reg;

    assign span     = i_reg - CW'(top_left_reg);
    assign area     = top_h_reg * span;
    assign best_ext = EXT_W'(best_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        i_next         = i_reg;
        sp_next        = sp_reg;
        cur_h_next     = cur_h_reg;
        top_h_next     = top_h_reg;
        top_left_next  = top_left_reg;
        push_left_next = push_left_reg;
        prod_next      = prod_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_area_next  = out_area_reg;
        out_ovf_next   = out_ovf_reg;

        h_we    = 1'b0;
        h_waddr = count_reg[IW-1:0];
        h_wdata = HB'(bars.data.bar_height);
        h_re    = 1'b0;
        h_raddr = i_reg[IW-1:0];
        s_we    = 1'b0;
        s_waddr = sp_reg[IW-1:0];
        s_wdata = {push_left_reg[IW-1:0], cur_h_reg};
        s_re    = 1'b0;
        s_raddr = IW'(sp_reg - CW'(2));

        case (state_reg)
            S_LOAD:
            begin
                if (bar_accept)
                begin
                    if (count_reg != CW'(MAX_BARS))
                    begin
                        h_we       = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (bars.data.last)
                    begin
                        i_next     = '0;
                        sp_next    = '0;
                        best_next  = '0;
                        state_next = S_HRD;
                    end
                end
            end
            S_HRD:
            begin
                h_re       = (i_reg != count_reg);
                state_next = S_HCAP;
            end
            S_HCAP:
            begin
                // the closing sentinel bar has height zero and pops everything
                cur_h_next     = (i_reg != count_reg) ? h_rdata : '0;
                push_left_next = i_reg;
                state_next     = S_CMP;
            end
            S_CMP:
            begin
                if (sp_reg != '0 && top_h_reg >= cur_h_reg)
                begin
                    prod_next      = area;
                    push_left_next = CW'(top_left_reg);
                    sp_next        = sp_reg - CW'(1);
                    s_re           = (sp_reg > CW'(1));
                    state_next     = S_POPW;
                end
                else if (i_reg != count_reg)
                begin
                    s_we          = 1'b1;
                    sp_next       = sp_reg + CW'(1);
                    top_h_next    = cur_h_reg;
                    top_left_next = push_left_reg[IW-1:0];
                    i_next        = i_reg + CW'(1);
                    state_next    = S_HRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POPW:
            begin
                if (prod_reg > best_reg)
                begin
                    best_next = prod_reg;
                end
                // new top of stack arrives from the ram this cycle
                if (sp_reg != '0)
                begin
                    top_h_next    = s_rdata[HB-1:0];
                    top_left_next = s_rdata[SW-1:HB];
                end
                state_next = S_CMP;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_area_next  = best_ext[MaxAreaW-1:0];
                    out_ovf_next   = dropped_reg;
                    count_next     = '0;
                    dropped_next   = 1'b0;
                    best_next      = '0;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            i_reg         <= '0;
            sp_reg        <= '0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            i_reg         <= i_next;
            sp_reg        <= sp_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_h_reg     <= cur_h_next;
        top_h_reg     <= top_h_next;
        top_left_reg  <= top_left_next;
        push_left_reg <= push_left_next;
        prod_reg      <= prod_next;
        out_area_reg  <= out_area_next;
        out_ovf_reg   <= out_ovf_next;
    end
endmodule

// ===== test/largest_histogram_rectangle_unit_tb.sv =====
// self-checking testbench for largest_histogram_rectangle_unit: directed table, capacity
// case and random histograms under four idle patterns, checked against an in-bench predictor
// depends on lhr_pkg, lhr_bar_if, lhr_result_if and the design under test
module largest_histogram_rectangle_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lhr_pkg::*;

    localparam int CAPACITY = 1024;
    localparam int RANDOM_ITEMS_PER_PHASE = 24;
    localparam logic [41:0] FULL_AREA = 42'h3FF_FFFF_FC00;

    typedef enum int {
        ANY_HEIGHT,
        LOW_HEIGHT,
        HIGH_HEIGHT,
        MIXED_HEIGHT
    } height_style_e;

    typedef struct packed {
        logic [BarHeightW-1:0] height;
        logic                  last;
        logic                  typed;
        logic [MaxAreaW-1:0]   area;
        logic                  overflow;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 23;
    localparam directed_row_t DIRECTED[DIRECTED_ROWS] = '{
        // single bars: zero and full height
        '{32'h0000_0000, 1'b1, 1'b1, 42'd0, 1'b0},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 42'hFFFF_FFFF, 1'b0},
        // all zero heights
        '{32'h0000_0000, 1'b0, 1'b0, 42'd0, 1'b0},
        '{32'h0000_0000, 1'b0, 1'b0, 42'd0, 1'b0},
        '{32'h0000_0000, 1'b1, 1'b1, 42'd0, 1'b0},
        // flat run, equal minima
        '{32'd5, 1'b0, 1'b0, 42'd0, 1'b0},
        '{32'd5, 1'b0, 1'b0, 42'd0, 1'b0},
        '{32'd5, 1'b1, 1'b1, 42'd15, 1'b0},
        // rising staircase
        '{32'd1, 1'b0, 1'b0, 42'd0, 1'b0},
        '{32'd2, 1'b0, 1'b0, 42'd0, 1'b0},
        '{32'd3, 1'b0, 1'b0, 42'd0, 1'b0},
        '{32'd4, 1'b1, 1'b0, 42'd0, 1'b0},
        // peak in the middle
        '{32'd2, 1'b0, 1'b0, 42'd0, 1'b0},
        '{32'd1, 1'b0, 1'b0, 42'd0, 1'b0},
        '{32'd5, 1'b0, 1'b0, 42'd0, 1'b0},
        '{32'd6, 1'b0, 1'b0, 42'd0, 1'b0},
        '{32'd2, 1'b0, 1'b0, 42'd0, 1'b0},
        '{32'd3, 1'b1, 1'b0, 42'd0, 1'b0},
        // product wider than the height field
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 42'd0, 1'b0},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 42'h1_FFFF_FFFE, 1'b0},
        // zero bar splitting two tall ones
        '{32'h8000_0000, 1'b0, 1'b0, 42'd0, 1'b0},
        '{32'h0000_0000, 1'b0, 1'b0, 42'd0, 1'b0},
        '{32'h8000_0000, 1'b1, 1'b0, 42'd0, 1'b0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lhr_bar_if    bars();
    lhr_result_if result();

    largest_histogram_rectangle_unit #(
        .MAX_BARS   (CAPACITY),
        .HEIGHT_BITS(BarHeightW)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .bars  (bars),
        .result(result)
    );

    // predictor state: bars of the open histogram and the drop flag
    logic [BarHeightW-1:0] open_bars[$];
    bit                    open_dropped;
    result_beat_t          pending_areas[$];

    int error_count = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // monotonic stack over the stored bars, a zero sentinel flushes it at the end
    function automatic logic [MaxAreaW-1:0] widest_area(input logic [BarHeightW-1:0] h[$]);
        int               rising[$];
        int               n;
        int               top;
        int               left;
        logic [63:0]      cur;
        logic [63:0]      area;
        logic [63:0]      best;
        n = h.size();
        best = '0;
        for (int i = 0; i <= n; i++)
        begin
            cur = (i < n) ? 64'(h[i]) : 64'd0;
            while (rising.size() > 0 && 64'(h[rising[$]]) >= cur)
            begin
                top = rising.pop_back();
                left = (rising.size() > 0) ? rising[$] + 1 : 0;
                area = 64'(h[top]) * 64'(i - left);
                if (area > best)
                    best = area;
            end
            if (i < n)
                rising.push_back(i);
        end
        return best[MaxAreaW-1:0];
    endfunction

    // one bar beat; the expectation is the typed one when typed is set
    task automatic send_bar(input logic [BarHeightW-1:0] height, input bit last,
                            input bit typed, input result_beat_t want);
        result_beat_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            bars.valid <= 1'b0;
            @(posedge clk);
        end
        bars.valid <= 1'b1;
        bars.data <= '{bar_height: height, last: last};
        @(posedge clk);
        while (!bars.ready)
            @(posedge clk);
        if (open_bars.size() < CAPACITY)
            open_bars.push_back(height);
        else
            open_dropped = 1'b1;
        if (last)
        begin
            predicted.max_area = widest_area(open_bars);
            predicted.overflow = open_dropped;
            pending_areas.push_back(typed ? want : predicted);
            open_bars.delete();
            open_dropped = 1'b0;
        end
    endtask

    // sender holds off until every expected area has come back
    task automatic drain_results();
        bars.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_areas.size() != 0);
    endtask

    function automatic logic [BarHeightW-1:0] pick_height(input height_style_e style);
        case (style)
            ANY_HEIGHT:  return $urandom;
            LOW_HEIGHT:  return $urandom_range(7);
            HIGH_HEIGHT: return 32'hFFFF_FFFF - $urandom_range(7);
            default:
            begin
                case ($urandom_range(3))
                    0:       return '0;
                    1:       return $urandom_range(15);
                    2:       return 32'hFFFF_FFFF - $urandom_range(15);
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    task automatic send_random_histogram(input int budget, output int length);
        height_style_e style;
        int            pick;
        pick = $urandom_range(99);
        if (pick < 70)
            length = $urandom_range(12, 1);
        else if (pick < 95)
            length = $urandom_range(64, 13);
        else
            length = $urandom_range(300, 65);
        if (length > budget)
            length = budget;
        style = height_style_e'($urandom_range(3));
        for (int i = 0; i < length; i++)
            send_bar(pick_height(style), i == length - 1, 1'b0, '0);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        int sent;
        int length;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        sent = 0;
        while (sent < RANDOM_ITEMS_PER_PHASE)
        begin
            send_random_histogram(RANDOM_ITEMS_PER_PHASE - sent, length);
            sent += length;
        end
    endtask

    always @(posedge clk)
        result.ready <= rst_n && ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_areas.size() == 0)
                report_mismatch($sformatf("unexpected result area %0d overflow %0b",
                                          result.data.max_area, result.data.overflow));
            else
            begin
                if (result.data.max_area !== pending_areas[0].max_area)
                    report_mismatch($sformatf("max_area got %0d want %0d",
                                              result.data.max_area, pending_areas[0].max_area));
                if (result.data.overflow !== pending_areas[0].overflow)
                    report_mismatch($sformatf("overflow got %0b want %0b",
                                              result.data.overflow, pending_areas[0].overflow));
                void'(pending_areas.pop_front());
            end
        end
    end

    initial
    begin
        result_beat_t want;
        bars.valid = 1'b0;
        bars.data = '0;
        result.ready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            want.max_area = DIRECTED[r].area;
            want.overflow = DIRECTED[r].overflow;
            send_bar(DIRECTED[r].height, DIRECTED[r].last, DIRECTED[r].typed, want);
        end
        drain_results();

        // capacity: full at top height, then the closing beat past full is dropped
        want.max_area = FULL_AREA;
        want.overflow = 1'b1;
        for (int i = 0; i < CAPACITY + 1; i++)
            send_bar(32'hFFFF_FFFF, i == CAPACITY, 1'b1, want);
        drain_results();

        run_random_phase(0, 0);
        drain_results();
        run_random_phase(79, 0);
        run_random_phase(0, 79);
        drain_results();
        run_random_phase(24, 24);

        bars.valid <= 1'b0;
        while (pending_areas.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
design/lhr_pkg.sv
design/lhr_bar_if.sv
design/lhr_result_if.sv
design/lhr_ram.sv
design/largest_histogram_rectangle_unit.sv
test/largest_histogram_rectangle_unit_tb.sv
